[rtl/rca_pkg.sv]
// ----------------------------------------------------------------------------
// rca_pkg: shared types and constants for the region crop aligner
// Function codes, status codes, register indexes and divider control.
// ----------------------------------------------------------------------------
package rca_pkg;

  localparam int unsigned IdTableDepthDef = 64;
  localparam int unsigned CropWFloorDef   = 1;
  localparam int unsigned CropHFloorDef   = 1;

  localparam int unsigned DivW = 18;  // operand width of the shared divider

  typedef enum logic [1:0] {
    FUNC_FRAME  = 2'd0,
    FUNC_REGION = 2'd1,
    FUNC_EOS    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_THROTTLED  = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_NO_ROOM    = 3'd3,
    ST_ZERO_ALIGN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_IMG_W   = 3'd0,
    REG_IMG_H   = 3'd1,
    REG_X_ALIGN = 3'd2,
    REG_Y_ALIGN = 3'd3,
    REG_W_ALIGN = 3'd4,
    REG_H_ALIGN = 3'd5,
    REG_REUSE   = 3'd6,
    REG_SPARE   = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SCAN, S_TUPD, S_XDIV, S_YDIV, S_WDIV, S_HDIV,
    S_FITX, S_FXDIV, S_FITY, S_FYDIV, S_OUT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/roi_crop_aligner_with_object_throttle.sv]
// ----------------------------------------------------------------------------
// roi_crop_aligner_with_object_throttle
// Per-object throttle and aligned crop fitting for region items.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid_i/in_ready_o with func_i and the region
// fields. Frame start and end-of-stream give no result; a region gives one
// result on out_valid_o/out_ready_i. Registers are written on cfg_valid_i /
// cfg_ready_o with cfg_index_i and cfg_data_i; the user must write them only
// while the block is idle, which the block does not enforce. One transaction
// at a time: in_ready_o is high only when idle. Frame start only counts the
// frame; end-of-stream sweeps the id table clear. A region is accepted, then
// the id table is scanned and updated (one entry per cycle from the id
// memory), then up to six passes of the shared divider, the two fits and the
// output follow; id 0 or interval 1 skips the scan. After reset the id table
// is swept clear while no item is taken. A result waits in the output
// register while the receiver stalls; the next item is accepted once it is
// taken.
// ----------------------------------------------------------------------------
module roi_crop_aligner_with_object_throttle
  import rca_pkg::*;
#(
  parameter int unsigned ID_TABLE_DEPTH = IdTableDepthDef,
  parameter int unsigned CROP_W_FLOOR   = CropWFloorDef,
  parameter int unsigned CROP_H_FLOOR   = CropHFloorDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] roi_x_i,
  input  logic [15:0] roi_y_i,
  input  logic [15:0] roi_w_i,
  input  logic [15:0] roi_h_i,
  input  logic [30:0] object_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] crop_x_o,
  output logic [15:0] crop_y_o,
  output logic [15:0] crop_w_o,
  output logic [15:0] crop_h_o
);

  localparam int unsigned AW = (ID_TABLE_DEPTH > 1) ? $clog2(ID_TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(ID_TABLE_DEPTH + 1);
  localparam logic [CW-1:0] LastIdx = CW'(ID_TABLE_DEPTH - 1);

  // configuration registers
  logic [15:0] img_w_q, img_h_q, xa_q, ya_q, wa_q, ha_q, reuse_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= '0;
      img_h_q <= '0;
      xa_q    <= 16'd1;
      ya_q    <= 16'd1;
      wa_q    <= 16'd1;
      ha_q    <= 16'd1;
      reuse_q <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_IMG_W:   img_w_q <= cfg_data_i;
        REG_IMG_H:   img_h_q <= cfg_data_i;
        REG_X_ALIGN: xa_q    <= cfg_data_i;
        REG_Y_ALIGN: ya_q    <= cfg_data_i;
        REG_W_ALIGN: wa_q    <= cfg_data_i;
        REG_H_ALIGN: ha_q    <= cfg_data_i;
        REG_REUSE:   reuse_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // id table memory: {valid, key, last_frame}
  logic [63:0] tab_mem [ID_TABLE_DEPTH];
  logic [63:0] tab_rd_q;
  logic        tab_we;
  logic [AW-1:0] tab_wa, tab_ra;
  logic [63:0] tab_wd;

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    tab_rd_q <= tab_mem[tab_ra];
  end

  // shared divider (remainder)
  div_req_t dreq;
  div_rsp_t drsp;
  rca_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  state_e        state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rd_v_q, rd_v_d;        // tab_rd_q holds entry rd_idx_q
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [31:0]   frame_q, frame_d;
  logic [17:0]   x_q, x_d, y_q, y_d, w_q, w_d, h_q, h_d;
  logic [30:0]   id_q, id_d;
  logic          hit_q, hit_d, free_q, free_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [2:0]    st_q, st_d;
  logic          out_v_q, out_v_d;
  logic [15:0]   ox_q, ox_d, oy_q, oy_d, ow_q, ow_d, oh_q, oh_d;
  logic          div_go_q, div_go_d;    // divider launched for this state
  logic [17:0]   limit;
  logic          zero_al;
  logic [63:0]   rd;

  assign in_ready_o = (state_q == S_IDLE) && !out_v_q;
  assign zero_al = (xa_q == '0) || (ya_q == '0) || (wa_q == '0) || (ha_q == '0);
  assign rd = tab_rd_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    rd_v_d     = 1'b0;
    rd_idx_d   = rd_idx_q;
    frame_d    = frame_q;
    x_d = x_q; y_d = y_q; w_d = w_q; h_d = h_q;
    id_d       = id_q;
    hit_d = hit_q; free_d = free_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    st_d       = st_q;
    out_v_d    = out_v_q && !out_ready_i;
    ox_d = ox_q; oy_d = oy_q; ow_d = ow_q; oh_d = oh_q;
    div_go_d   = 1'b0;
    tab_we     = 1'b0;
    tab_wa     = idx_q[AW-1:0];
    tab_wd     = '0;
    tab_ra     = idx_q[AW-1:0];
    dreq       = '0;
    limit      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          unique case (func_e'(func_i))
            FUNC_FRAME: frame_d = frame_q + 32'd1;
            FUNC_EOS: begin
              frame_d = '0;
              idx_d   = '0;
              state_d = S_CLEAR;
            end
            FUNC_REGION: begin
              x_d = {2'b0, roi_x_i}; y_d = {2'b0, roi_y_i};
              w_d = {2'b0, roi_w_i}; h_d = {2'b0, roi_h_i};
              id_d = object_id_i;
              hit_d = 1'b0; free_d = 1'b0;
              st_d = ST_OK;
              if (reuse_q == 16'd1 || object_id_i == '0) begin
                state_d = S_XDIV;
              end else begin
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        tab_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q == LastIdx) state_d = S_IDLE;
      end
      S_SCAN: begin
        // issue read of idx_q, evaluate previous entry
        if (idx_q <= LastIdx) begin
          rd_v_d   = 1'b1;
          rd_idx_d = idx_q[AW-1:0];
          idx_d    = idx_q + 1'b1;
        end
        if (rd_v_q) begin
          if (rd[63]) begin
            if (!hit_q && !hit_d && rd[62:32] == id_q) begin
              hit_d = 1'b1;
              hit_idx_d = rd_idx_q;
            end
          end else if (!free_q) begin
            free_d = 1'b1;
            free_idx_d = rd_idx_q;
          end
        end
        if (idx_q > LastIdx && !rd_v_q) begin
          tab_ra  = hit_idx_q;
          state_d = S_TUPD;
        end
      end
      S_TUPD: begin
        // tab_rd_q holds the hit entry when there was a hit
        state_d = S_XDIV;
        if (hit_q) begin
          if (reuse_q == '0) begin
            st_d = ST_THROTTLED;
            state_d = S_OUT;
          end else if ((frame_q - rd[31:0]) > {16'd0, reuse_q}) begin
            tab_we = 1'b1;
            tab_wa = hit_idx_q;
            tab_wd = {1'b1, id_q, frame_q};
          end else begin
            st_d = ST_THROTTLED;
            state_d = S_OUT;
          end
        end else if (free_q) begin
          tab_we = 1'b1;
          tab_wa = free_idx_q;
          tab_wd = {1'b1, id_q, frame_q};
        end
      end
      S_XDIV, S_YDIV, S_WDIV, S_HDIV, S_FXDIV, S_FYDIV: begin
        if (zero_al && state_q == S_XDIV) begin
          st_d = ST_ZERO_ALIGN;
          state_d = S_OUT;
        end else if (!div_go_q) begin
          div_go_d = 1'b1;
          dreq.start = 1'b1;
          unique case (state_q)
            S_XDIV:  begin dreq.num = x_q; dreq.den = {2'b0, xa_q}; end
            S_YDIV:  begin dreq.num = y_q; dreq.den = {2'b0, ya_q}; end
            S_WDIV:  begin dreq.num = w_q; dreq.den = {2'b0, wa_q}; end
            S_HDIV:  begin dreq.num = h_q; dreq.den = {2'b0, ha_q}; end
            S_FXDIV: begin dreq.num = x_q; dreq.den = {2'b0, xa_q}; end
            default: begin dreq.num = y_q; dreq.den = {2'b0, ya_q}; end
          endcase
        end else if (!drsp.done) begin
          div_go_d = 1'b1;
        end else begin
          unique case (state_q)
            S_XDIV: begin
              x_d = x_q - drsp.rem; w_d = w_q + drsp.rem; state_d = S_YDIV;
            end
            S_YDIV: begin
              y_d = y_q - drsp.rem; h_d = h_q + drsp.rem;
              if (w_q < 18'(CROP_W_FLOOR)) w_d = 18'(CROP_W_FLOOR);
              if (h_d < 18'(CROP_H_FLOOR)) h_d = 18'(CROP_H_FLOOR);
              state_d = S_WDIV;
            end
            S_WDIV: begin
              if (drsp.rem != '0) w_d = w_q - drsp.rem + {2'b0, wa_q};
              state_d = S_HDIV;
            end
            S_HDIV: begin
              if (drsp.rem != '0) h_d = h_q - drsp.rem + {2'b0, ha_q};
              state_d = S_FITX;
            end
            S_FXDIV: begin
              if (drsp.rem != '0) begin
                st_d = ST_MISALIGNED; state_d = S_OUT;
              end else state_d = S_FITY;
            end
            default: begin
              if (drsp.rem != '0) st_d = ST_MISALIGNED;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_FITX: begin
        limit = {2'b0, img_w_q};
        state_d = S_FITY;
        if ({1'b0, x_q} + {1'b0, w_q} > {1'b0, limit}) begin
          if (w_q > limit) begin
            st_d = ST_NO_ROOM; state_d = S_OUT;
          end else begin
            x_d = limit - w_q; state_d = S_FXDIV;
          end
        end
      end
      S_FITY: begin
        limit = {2'b0, img_h_q};
        state_d = S_OUT;
        if ({1'b0, y_q} + {1'b0, h_q} > {1'b0, limit}) begin
          if (h_q > limit) st_d = ST_NO_ROOM;
          else begin
            y_d = limit - h_q; state_d = S_FYDIV;
          end
        end
      end
      S_OUT: begin
        if (!out_v_q) begin
          out_v_d = 1'b1;
          if (st_q == ST_OK) begin
            ox_d = x_q[15:0]; oy_d = y_q[15:0]; ow_d = w_q[15:0]; oh_d = h_q[15:0];
          end else begin
            ox_d = '0; oy_d = '0; ow_d = '0; oh_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      idx_q    <= '0;
      rd_v_q   <= 1'b0;
      frame_q  <= '0;
      out_v_q  <= 1'b0;
      div_go_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      st_q     <= ST_OK;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_v_q   <= rd_v_d;
      frame_q  <= frame_d;
      out_v_q  <= out_v_d;
      div_go_q <= div_go_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
      st_q     <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    x_q <= x_d; y_q <= y_d; w_q <= w_d; h_q <= h_d;
    id_q       <= id_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    ox_q <= ox_d; oy_q <= oy_d; ow_q <= ow_d; oh_q <= oh_d;
  end

  assign out_valid_o = out_v_q;
  assign status_o    = st_q;
  assign crop_x_o    = ox_q;
  assign crop_y_o    = oy_q;
  assign crop_w_o    = ow_q;
  assign crop_h_o    = oh_q;

endmodule

[rtl/rca_div.sv]
// ----------------------------------------------------------------------------
// rca_div: shared restoring divider
// One quotient bit per cycle; yields the remainder only.
// ----------------------------------------------------------------------------
module rca_div
  import rca_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] num_q, num_d, den_q, den_d;
  logic [DivW:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DivW:0]   trial;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DivW-1:0], num_q[DivW-1]};
    if (req_i.start) begin
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[DivW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) rem_d = trial - {1'b0, den_q};
      else                        rem_d = trial;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[DivW-1:0];

endmodule

[rtl/rca_checker.sv]
// ----------------------------------------------------------------------------
// rca_checker: port-level checks for the region crop aligner
// Watches handshakes and result consistency; bound to the top level.
// ----------------------------------------------------------------------------
module rca_checker
  import rca_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [15:0] crop_x_o,
  input logic [15:0] crop_w_o
);

  // a pending result blocks new input transactions
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result changed");

  // non-ok results carry zero geometry
  a_zero_geom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> crop_x_o == '0 && crop_w_o == '0)
    else $error("geometry on failed crop");

  // status code range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_ZERO_ALIGN) else $error("bad status");

endmodule

bind roi_crop_aligner_with_object_throttle rca_checker u_rca_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .crop_x_o, .crop_w_o
);
